>>> hw/rtl/lvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvs_pkg
// Shared constants, datapath operation codes and status type for the
// Legendre value and slope block.
// ----------------------------------------------------------------------------
package lvs_pkg;

	localparam int MAX_DEGREE = 64;
	localparam int FRAC_BITS  = 30;

	localparam int DEGREE_W = 7;
	localparam int POINT_W  = 32;
	localparam int POLY_W   = 32;
	localparam int SLOPE_W  = 43;

	localparam logic signed [33:0] ONE_FX    = 34'sd1 <<< FRAC_BITS;
	localparam logic [43:0]        SLOPE_LIM =
		44'(MAX_DEGREE * (MAX_DEGREE + 1) / 2) << FRAC_BITS;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MUL,
		OP_ACC,
		OP_DIVA,
		OP_DIVB,
		OP_DIVC,
		OP_FMUL,
		OP_FSUB,
		OP_QINIT,
		OP_QSTEP,
		OP_FINAL
	} lvs_op_t;

	typedef struct packed {
		logic deg_lt2;
		logic last_step;
		logic skip_div;
		logic div_last;
	} lvs_status_t;

endpackage

>>> hw/rtl/lvs_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvs_in_if
// Input channel: degree and evaluation point with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvs_in_if import lvs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [DEGREE_W-1:0]       degree;
	logic signed [POINT_W-1:0] point;

	modport source (output valid, output degree, output point, input ready);
	modport sink (input valid, input degree, input point, output ready);
endinterface

>>> hw/rtl/lvs_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvs_out_if
// Result channel: polynomial value and slope with valid/ready handshake.
// ----------------------------------------------------------------------------
interface lvs_out_if import lvs_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [POLY_W-1:0]  poly_value;
	logic signed [SLOPE_W-1:0] slope;

	modport source (output valid, output poly_value, output slope, input ready);
	modport sink (input valid, input poly_value, input slope, output ready);
endinterface

>>> hw/rtl/lvs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvs_ctrl
// Sequencer that steps the datapath through the recurrence, the slope
// terms and the bit-serial slope division, and owns the result valid flag.
// ----------------------------------------------------------------------------
module lvs_ctrl import lvs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	output logic        result_valid,
	input  logic        result_ready,
	input  lvs_status_t status,
	output lvs_op_t     op
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_START,
		S_MUL,
		S_ACC,
		S_DIVA,
		S_DIVB,
		S_DIVC,
		S_FMUL,
		S_FSUB,
		S_QINIT,
		S_QSTEP,
		S_FINAL
	} state_t;

	state_t state_q;
	logic   result_valid_q;
	logic   out_free;

	assign out_free     = !result_valid_q || result_ready;
	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = result_valid_q;

	always_comb begin
		unique case (state_q)
			S_IDLE:  op = item_valid ? OP_LOAD : OP_NONE;
			S_START: op = OP_NONE;
			S_MUL:   op = OP_MUL;
			S_ACC:   op = OP_ACC;
			S_DIVA:  op = OP_DIVA;
			S_DIVB:  op = OP_DIVB;
			S_DIVC:  op = OP_DIVC;
			S_FMUL:  op = OP_FMUL;
			S_FSUB:  op = OP_FSUB;
			S_QINIT: op = OP_QINIT;
			S_QSTEP: op = OP_QSTEP;
			S_FINAL: op = out_free ? OP_FINAL : OP_NONE;
			default: op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready && state_q != S_FINAL) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_START;
					end
				end
				S_START: state_q <= status.deg_lt2 ? S_FINAL : S_MUL;
				S_MUL:   state_q <= S_ACC;
				S_ACC:   state_q <= S_DIVA;
				S_DIVA:  state_q <= S_DIVB;
				S_DIVB:  state_q <= S_DIVC;
				S_DIVC:  state_q <= status.last_step ? S_FMUL : S_MUL;
				S_FMUL:  state_q <= S_FSUB;
				S_FSUB:  state_q <= S_QINIT;
				S_QINIT: state_q <= status.skip_div ? S_FINAL : S_QSTEP;
				S_QSTEP: begin
					if (status.div_last) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/lvs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lvs_datapath
// Recurrence registers, reciprocal-table divider by the step index, slope
// terms, restoring slope divider and the result registers.
// ----------------------------------------------------------------------------
module lvs_datapath import lvs_pkg::*; (
	input  logic                      clk,
	input  lvs_op_t                   op,
	input  logic [DEGREE_W-1:0]       degree,
	input  logic signed [POINT_W-1:0] point,
	output lvs_status_t               status,
	output logic signed [POLY_W-1:0]  poly_value,
	output logic signed [SLOPE_W-1:0] slope
);

	// Product rounded to nearest with ties away from zero.
	function automatic logic signed [33:0] fx_mul(input logic signed [31:0] a,
			input logic signed [33:0] b);
		logic signed [65:0] pr;
		logic [65:0]        mg;
		logic [65:0]        rd;
		logic [33:0]        r;
		pr = 66'(a) * 66'(b);
		mg = pr[65] ? 66'(-pr) : 66'(pr);
		rd = (mg + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r  = rd[33:0];
		return pr[65] ? -signed'(r) : signed'(r);
	endfunction

	logic [31:0] recip_b [0:MAX_DEGREE];

	for (genvar i = 0; i <= MAX_DEGREE; i++) begin : g_recip
		localparam longint unsigned Div = (i < 2) ? 2 : i;
		localparam longint unsigned Rv  = ((64'd1 << 32) + Div - 1) / Div;
		assign recip_b[i] = Rv[31:0];
	end

	logic [6:0]         n_q;
	logic signed [31:0] x_q;
	logic [6:0]         p_q;
	logic signed [33:0] pm_q;
	logic signed [33:0] pc_q;
	logic signed [33:0] t_q;
	logic [39:0]        mp_q;
	logic               neg_q;
	logic [20:0]        qa_q;
	logic [24:0]        n2_q;
	logic signed [33:0] xx_q;
	logic signed [33:0] xp_q;
	logic [30:0]        dmag_q;
	logic [41:0]        m_q;
	logic               sneg_q;
	logic               dzero_q;
	logic [11:0]        limn_q;
	logic               epneg_q;
	logic [30:0]        rem_q;
	logic [42:0]        low_q;
	logic [42:0]        quo_q;
	logic [5:0]         cnt_q;
	logic               ovf_q;
	logic signed [31:0] poly_q;
	logic signed [42:0] slope_q;

	logic [6:0]         n_clamp;
	logic signed [31:0] x_clamp;
	logic [31:0]        rb;
	logic [32:0]        rb_sum;
	logic [28:0]        ra;
	logic [7:0]         c1;
	logic [6:0]         c2;
	logic signed [40:0] acc;
	logic [40:0]        acc_mag;
	logic [49:0]        qa_prod;
	logic [27:0]        qa_back;
	logic [20:0]        ra_rem;
	logic [56:0]        qb_prod;
	logic [39:0]        q_full;
	logic [39:0]        q_signed;
	logic signed [34:0] num;
	logic [34:0]        num_mag;
	logic [12:0]        n_sq;
	logic               ovf_c;
	logic [30:0]        trial;
	logic               take;
	logic               rnd_up;
	logic [43:0]        q_rnd;
	logic [43:0]        s_mag;
	logic signed [33:0] poly_sat;

	assign n_clamp = (degree > 7'(MAX_DEGREE)) ? 7'(MAX_DEGREE) : degree;
	assign x_clamp = (point > 32'(ONE_FX)) ? 32'(ONE_FX) :
		((point < -32'(ONE_FX)) ? -32'(ONE_FX) : point);

	assign rb     = recip_b[p_q];
	assign rb_sum = 33'(rb) + 33'd15;
	assign ra     = rb_sum[32:4];

	assign c1      = {p_q, 1'b0} - 8'd1;
	assign c2      = p_q - 7'd1;
	assign acc     = $signed({1'b0, c1}) * 41'(t_q) - $signed({1'b0, c2}) * 41'(pm_q);
	assign acc_mag = acc[40] ? 41'(-acc) : 41'(acc);

	assign qa_prod  = 50'(mp_q[39:19]) * 50'(ra);
	assign qa_back  = 28'(qa_q) * 28'(p_q);
	assign ra_rem   = mp_q[39:19] - qa_back[20:0];
	assign qb_prod  = 57'(n2_q) * 57'(rb);
	assign q_full   = {qa_q, qb_prod[50:32]};
	assign q_signed = neg_q ? -q_full : q_full;

	assign num     = 35'(xp_q) - 35'(pm_q);
	assign num_mag = num[34] ? 35'(-num) : 35'(num);
	assign n_sq    = 13'(n_q) * 13'(n_q + 7'd1);

	assign ovf_c = {2'b00, m_q[41:13]} >= dmag_q;
	assign trial = {rem_q[29:0], low_q[42]};
	assign take  = trial >= dmag_q;

	assign rnd_up = {rem_q, 1'b0} >= {1'b0, dmag_q};
	assign q_rnd  = {1'b0, quo_q} + 44'(rnd_up);
	assign s_mag  = ovf_q ? SLOPE_LIM : ((q_rnd > SLOPE_LIM) ? SLOPE_LIM : q_rnd);

	assign poly_sat = (pc_q > ONE_FX) ? ONE_FX : ((pc_q < -ONE_FX) ? -ONE_FX : pc_q);

	always_ff @(posedge clk) begin
		unique case (op)
			OP_LOAD: begin
				n_q  <= n_clamp;
				x_q  <= x_clamp;
				p_q  <= 7'd2;
				pm_q <= ONE_FX;
				pc_q <= 34'(x_clamp);
			end
			OP_MUL: t_q <= fx_mul(x_q, pc_q);
			OP_ACC: begin
				mp_q  <= acc_mag[39:0] + 40'(p_q >> 1);
				neg_q <= acc[40];
			end
			OP_DIVA: qa_q <= qa_prod[48:28];
			OP_DIVB: n2_q <= {ra_rem[5:0], mp_q[18:0]};
			OP_DIVC: begin
				pm_q <= pc_q;
				pc_q <= signed'(q_signed[33:0]);
				p_q  <= p_q + 7'd1;
			end
			OP_FMUL: begin
				xx_q <= fx_mul(x_q, 34'(x_q));
				xp_q <= fx_mul(x_q, pc_q);
			end
			OP_FSUB: begin
				dzero_q <= (xx_q == ONE_FX);
				dmag_q  <= 31'(ONE_FX - xx_q);
				m_q     <= 42'(n_q) * 42'(num_mag);
				sneg_q  <= (num > 35'sd0);
				limn_q  <= n_sq[12:1];
				epneg_q <= x_q[31] && !n_q[0];
			end
			OP_QINIT: begin
				rem_q <= {2'b00, m_q[41:13]};
				low_q <= {m_q[12:0], 30'b0};
				quo_q <= '0;
				cnt_q <= '0;
				ovf_q <= ovf_c;
			end
			OP_QSTEP: begin
				rem_q <= take ? trial - dmag_q : trial;
				quo_q <= {quo_q[41:0], take};
				low_q <= {low_q[41:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
			end
			OP_FINAL: begin
				if (n_q == 7'd0) begin
					poly_q  <= 32'(ONE_FX);
					slope_q <= '0;
				end else if (n_q == 7'd1) begin
					poly_q  <= x_q;
					slope_q <= 43'(ONE_FX);
				end else begin
					poly_q <= 32'(poly_sat);
					if (dzero_q) begin
						slope_q <= epneg_q ? -(43'(limn_q) << FRAC_BITS) :
							(43'(limn_q) << FRAC_BITS);
					end else begin
						slope_q <= sneg_q ? -s_mag[42:0] : s_mag[42:0];
					end
				end
			end
			default: ;
		endcase
	end

	assign status.deg_lt2   = (n_q < 7'd2);
	assign status.last_step = (p_q == n_q);
	assign status.skip_div  = dzero_q || ovf_c;
	assign status.div_last  = (cnt_q == 6'd42);

	assign poly_value = poly_q;
	assign slope      = slope_q;

endmodule

>>> hw/rtl/legendre_value_and_slope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// legendre_value_and_slope
// Legendre polynomial P_n(x) and its derivative for one degree and point.
// ----------------------------------------------------------------------------
// One item is processed at a time. Degrees 0 and 1 go from the start state
// straight to the final state, which writes the result register. For n of 2
// or more each recurrence step is a product, a weighted sum and a two-part
// division by the step index through a reciprocal table, and the slope uses
// a restoring divider that resolves one of 43 quotient bits per cycle; the
// divider is bypassed at the endpoints and on saturation. A new item is
// accepted as soon as the sequencer returns to idle, while a finished result
// still waits for its transfer in the output register.
// ----------------------------------------------------------------------------
module legendre_value_and_slope import lvs_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	lvs_in_if.sink   item,
	lvs_out_if.source result
);

	lvs_op_t     op;
	lvs_status_t status;

	lvs_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.status       (status),
		.op           (op)
	);

	lvs_datapath u_datapath (
		.clk        (clk),
		.op         (op),
		.degree     (item.degree),
		.point      (item.point),
		.status     (status),
		.poly_value (result.poly_value),
		.slope      (result.slope)
	);

endmodule

>>> test/tb_legendre_value_and_slope.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_legendre_value_and_slope
// Self-checking bench that drives degree and point pairs through the input
// channel and compares each result with a fixed-point Legendre predictor.
// It covers directed corners such as degrees 0 and 1, oversized degrees,
// points at and beyond the endpoints, and slope saturation. Random traffic
// follows with random input gaps and random back pressure on the results.
// ----------------------------------------------------------------------------
module tb_legendre_value_and_slope;
	import lvs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 400;
	localparam int RANDOM_ITEMS   = 800;

	typedef struct {
		logic [DEGREE_W-1:0] degree;
		logic [POINT_W-1:0]  point;
		bit                  hold;
	} pending_t;

	typedef struct {
		logic [POLY_W-1:0]  poly_value;
		logic [SLOPE_W-1:0] slope;
	} legendre_t;

	logic clk = 1'b0;
	logic arst_n;

	lvs_in_if  item ();
	lvs_out_if result ();

	legendre_value_and_slope uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item.sink),
		.result (result.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pending_t  pending_q[$];
	legendre_t expected_q[$];
	int        gap_left;
	int        stall_left;
	int        idle_cycles;
	int        items_sent;
	int        results_checked;
	int        mismatches;
	int        endpoint_items;
	int        burst_mode;

	function automatic longint fx_product(longint a, longint b);
		logic [127:0] ma, mb, pr;
		longint       r;
		ma = (a < 0) ? 128'(-a) : 128'(a);
		mb = (b < 0) ? 128'(-b) : 128'(b);
		pr = ((ma * mb) + (128'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		r = longint'(pr[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint round_divide(longint a, longint d);
		longint m;
		m = (a < 0) ? -a : a;
		m = (m + d / 2) / d;
		return (a < 0) ? -m : m;
	endfunction

	function automatic legendre_t legendre_eval(logic [DEGREE_W-1:0] degree,
			logic [POINT_W-1:0] point);
		longint       one, n, x, prev, cur, nxt, acc, poly, slope, num, den, lim;
		logic [127:0] wide, quot, rem;
		legendre_t    r;
		one = longint'(1) << FRAC_BITS;
		n = (degree > MAX_DEGREE) ? MAX_DEGREE : degree;
		x = longint'(signed'(point));
		if (x > one) x = one;
		if (x < -one) x = -one;
		if (n == 0) begin
			poly = one;
			slope = 0;
		end else if (n == 1) begin
			poly = x;
			slope = one;
		end else begin
			prev = one;
			cur = x;
			for (longint p = 2; p <= n; p++) begin
				acc = (2 * p - 1) * fx_product(x, cur) - (p - 1) * prev;
				nxt = round_divide(acc, p);
				prev = cur;
				cur = nxt;
			end
			poly = cur;
			den = fx_product(x, x) - one;
			if (den == 0) begin
				lim = (n * (n + 1) / 2) << FRAC_BITS;
				slope = (x < 0 && n[0] == 1'b0) ? -lim : lim;
			end else begin
				num = fx_product(x, cur) - prev;
				wide = 128'(n * ((num < 0) ? -num : num)) << FRAC_BITS;
				quot = wide / 128'(-den);
				rem = wide % 128'(-den);
				if (quot <= 128'(SLOPE_LIM) && 2 * rem >= 128'(-den))
					quot = quot + 1;
				if (quot > 128'(SLOPE_LIM))
					quot = 128'(SLOPE_LIM);
				slope = (num > 0) ? -longint'(quot[63:0]) : longint'(quot[63:0]);
			end
		end
		if (poly > one) poly = one;
		if (poly < -one) poly = -one;
		r.poly_value = poly[POLY_W-1:0];
		r.slope = slope[SLOPE_W-1:0];
		return r;
	endfunction

	function automatic int draw_wait();
		return burst_mode ? 0 : $urandom_range(0, 18);
	endfunction

	// Sender side.
	always @(posedge clk) begin
		if (arst_n) begin
			if (item.valid && item.ready) begin
				expected_q.push_back(legendre_eval(item.degree, item.point));
				items_sent <= items_sent + 1;
				if (item.point == POINT_W'(ONE_FX) || item.point == -POINT_W'(ONE_FX))
					endpoint_items <= endpoint_items + 1;
				gap_left <= draw_wait();
				if (burst_mode && pending_q.size() > 0 && !pending_q[0].hold) begin
					item.degree <= pending_q[0].degree;
					item.point <= pending_q[0].point;
					void'(pending_q.pop_front());
				end else begin
					item.valid <= 1'b0;
				end
			end else if (!item.valid) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
				end else if (pending_q.size() > 0 &&
						(!pending_q[0].hold || expected_q.size() == 0)) begin
					item.valid <= 1'b1;
					item.degree <= pending_q[0].degree;
					item.point <= pending_q[0].point;
					void'(pending_q.pop_front());
				end
			end
		end
	end

	// Receiver side.
	always @(posedge clk) begin
		legendre_t exp_r;
		int        s;
		if (arst_n) begin
			if (result.valid && result.ready) begin
				results_checked <= results_checked + 1;
				if (expected_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected result: poly %h slope %h",
							result.poly_value, result.slope);
				end else begin
					exp_r = expected_q.pop_front();
					if (result.poly_value !== exp_r.poly_value ||
							result.slope !== exp_r.slope) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("mismatch: poly exp %h got %h, slope exp %h got %h",
								exp_r.poly_value, result.poly_value,
								exp_r.slope, result.slope);
					end
				end
				s = draw_wait();
				stall_left <= s;
				result.ready <= (s == 0);
			end else if (!result.ready) begin
				if (stall_left > 0)
					stall_left <= stall_left - 1;
				else
					result.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item.valid && item.ready) || (result.valid && result.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("legendre_value_and_slope test failed");
			$finish;
		end
	end

	task automatic add_item(int degree, logic [POINT_W-1:0] point, bit hold);
		pending_t p;
		p.degree = degree[DEGREE_W-1:0];
		p.point = point;
		p.hold = hold;
		pending_q.push_back(p);
	endtask

	initial begin
		logic [POINT_W-1:0] one_pt, pt;
		int                 deg;
		one_pt = POINT_W'(ONE_FX);
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.degree = '0;
		item.point = '0;
		result.ready = 1'b0;
		gap_left = 0;
		stall_left = 0;
		idle_cycles = 0;
		items_sent = 0;
		results_checked = 0;
		mismatches = 0;
		endpoint_items = 0;
		burst_mode = 0;

		add_item(0, 32'h8000_0000, 1'b0);
		add_item(1, 32'h7fff_ffff, 1'b0);
		add_item(1, -one_pt, 1'b0);
		add_item(2, one_pt, 1'b0);
		add_item(2, -one_pt, 1'b0);
		add_item(3, -one_pt, 1'b0);
		add_item(64, one_pt, 1'b0);
		add_item(64, -one_pt, 1'b0);
		add_item(127, 32'h0000_0000, 1'b0);
		add_item(65, one_pt - 1, 1'b0);
		add_item(64, -one_pt + 1, 1'b0);
		add_item(2, 32'h7fff_ffff, 1'b0);
		add_item(5, 32'h8000_0000, 1'b0);
		add_item(7, 32'h0000_0001, 1'b0);
		add_item(10, 32'hffff_ffff, 1'b1);
		add_item(40, one_pt - 16, 1'b0);
		add_item(33, 32'h2000_0000, 1'b0);
		add_item(64, 32'h5555_5555, 1'b0);
		add_item(100, 32'haaaa_aaaa, 1'b0);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			case ($urandom_range(0, 9))
				0: pt = $urandom();
				1: pt = ($urandom_range(0, 1) ? one_pt : -one_pt)
					+ POINT_W'(signed'($urandom_range(0, 64)) - 32);
				default: pt = POINT_W'(signed'($urandom_range(0, 2 * ONE_FX)) - ONE_FX);
			endcase
			case ($urandom_range(0, 9))
				0: deg = $urandom_range(0, 127);
				1: deg = $urandom_range(40, 64);
				default: deg = $urandom_range(0, 16);
			endcase
			add_item(deg, pt, (i % 200) == 199);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_q.size() > 0) begin
			@(posedge clk);
			if ((items_sent / 100) % 3 == 2)
				burst_mode = 1;
			else
				burst_mode = 0;
		end
		burst_mode = 0;
		while (item.valid || expected_q.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		mismatches = mismatches + expected_q.size();
		$display("Sent %0d items (%0d at an endpoint), checked %0d results, %0d errors.",
			items_sent, endpoint_items, results_checked, mismatches);
		if (mismatches == 0)
			$display("legendre_value_and_slope test passed");
		else
			$display("legendre_value_and_slope test failed");
		$finish;
	end

endmodule
